// ===== design/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked check, off while reset is high
`define EN2F_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form
`define EN2F_IMPLY(lbl, ante, cons, msg) \
  `EN2F_CHECK(lbl, (ante) |-> cons, msg)

`endif

// ===== design/en2f_pkg.sv =====
`timescale 1ns / 1ps
package en2f_pkg;

  localparam int WORK_FRAC = 62;
  localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6A;
  localparam int TAYLOR_TERMS = 24;
  localparam int DIV_STEPS = 8;

  typedef enum logic [1:0] {
    REG_REF_FREQ = 2'd0,
    REG_REF_NOTE = 2'd1,
    REG_OCT_DIV  = 2'd2
  } cfg_reg_t;

  // one word travelling down the series pipeline
  typedef struct packed {
    logic        vld;
    logic [7:0]  q;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
  } en2f_item_t;

endpackage

// ===== design/en2f_xgen.sv =====
`timescale 1ns / 1ps
module en2f_xgen (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [6:0]           note,
  input  logic [6:0]           ref_note,
  input  logic [7:0]           divisor,
  output en2f_pkg::en2f_item_t item
);
  import en2f_pkg::*;

  localparam int NW = 72;
  localparam int NSTG = NW / DIV_STEPS;

  // octave split: floor division of the note difference
  logic signed [7:0] diff;
  logic [6:0] mag;
  logic [8:0] rem;
  logic [6:0] qm;
  logic [7:0] q_next;
  logic [7:0] r_next;

  assign diff = $signed({1'b0, note}) - $signed({1'b0, ref_note});
  assign mag  = diff[7] ? 7'(-diff) : diff[6:0];

  always_comb begin
    rem = '0;
    qm  = '0;
    for (int i = 6; i >= 0; i--) begin
      rem = {rem[7:0], mag[i]};
      if (rem >= {1'b0, divisor}) begin
        rem   = rem - {1'b0, divisor};
        qm[i] = 1'b1;
      end
    end
    if (!diff[7]) begin
      q_next = {1'b0, qm};
      r_next = rem[7:0];
    end else if (rem == '0) begin
      q_next = 8'(-{1'b0, qm});
      r_next = '0;
    end else begin
      q_next = 8'(-{1'b0, qm}) - 8'd1;
      r_next = divisor - rem[7:0];
    end
  end

  logic       s1_vld;
  logic [7:0] s1_q;
  logic [7:0] s1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
    s1_q <= q_next;
    s1_r <= r_next;
  end

  // r * ln2, then long division by the step count
  logic            dv_vld [0:NSTG];
  logic [7:0]      dv_q   [0:NSTG];
  logic [7:0]      dv_rem [0:NSTG];
  logic [NW-1:0]   dv_w   [0:NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= s1_vld;
    end
    dv_q[0]   <= s1_q;
    dv_rem[0] <= '0;
    dv_w[0]   <= NW'(s1_r) * NW'(LN2_Q62);
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_div
    logic [8:0]    rm;
    logic [NW-1:0] w;

    always_comb begin
      rm = {1'b0, dv_rem[g]};
      w  = dv_w[g];
      for (int i = 0; i < DIV_STEPS; i++) begin
        rm = {rm[7:0], w[NW-1]};
        w  = {w[NW-2:0], 1'b0};
        if (rm >= {1'b0, divisor}) begin
          rm   = rm - {1'b0, divisor};
          w[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g+1] <= 1'b0;
      end else begin
        dv_vld[g+1] <= dv_vld[g];
      end
      dv_q[g+1]   <= dv_q[g];
      dv_rem[g+1] <= rm[7:0];
      dv_w[g+1]   <= w;
    end
  end

  always_comb begin
    item.vld  = dv_vld[NSTG];
    item.q    = dv_q[NSTG];
    item.x    = dv_w[NSTG][63:0];
    item.term = 64'd1 << WORK_FRAC;
    item.sum  = 64'd1 << WORK_FRAC;
  end

endmodule

// ===== design/en2f_term.sv =====
`timescale 1ns / 1ps
module en2f_term #(
  parameter int K = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  en2f_pkg::en2f_item_t item_i,
  output en2f_pkg::en2f_item_t item_o
);
  import en2f_pkg::*;

  // partial products of term * x
  en2f_item_t  a_item;
  logic [63:0] a_p00, a_p01, a_p10, a_p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_item.vld <= 1'b0;
    end else begin
      a_item <= item_i;
    end
    a_p00 <= item_i.term[31:0]  * item_i.x[31:0];
    a_p01 <= item_i.term[31:0]  * item_i.x[63:32];
    a_p10 <= item_i.term[63:32] * item_i.x[31:0];
    a_p11 <= item_i.term[63:32] * item_i.x[63:32];
  end

  logic [127:0] prod;
  en2f_item_t   b_item;
  logic [63:0]  b_t;

  assign prod = {a_p11, a_p00} + {32'b0, a_p01, 32'b0} + {32'b0, a_p10, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_item.vld <= 1'b0;
    end else begin
      b_item <= a_item;
    end
    b_t <= prod[WORK_FRAC+63:WORK_FRAC];
  end

  en2f_item_t  fin_item;
  logic [63:0] fin_t;

  if (K == 1) begin : g_nodiv
    assign fin_item = b_item;
    assign fin_t    = b_t;
  end else begin : g_div
    localparam int KW   = $clog2(K + 1);
    localparam int NSTG = 64 / DIV_STEPS;
    localparam logic [KW:0] KDIV = (KW + 1)'(K);

    en2f_item_t  dk_item [0:NSTG];
    logic [63:0] dk_w    [0:NSTG];
    logic [KW-1:0] dk_rem [0:NSTG];

    assign dk_item[0] = b_item;
    assign dk_w[0]    = b_t;
    assign dk_rem[0]  = '0;

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
      logic [KW:0] rm;
      logic [63:0] w;

      always_comb begin
        rm = {1'b0, dk_rem[g]};
        w  = dk_w[g];
        for (int i = 0; i < DIV_STEPS; i++) begin
          rm = {rm[KW-1:0], w[63]};
          w  = {w[62:0], 1'b0};
          if (rm >= KDIV) begin
            rm   = rm - KDIV;
            w[0] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dk_item[g+1].vld <= 1'b0;
        end else begin
          dk_item[g+1] <= dk_item[g];
        end
        dk_w[g+1]   <= w;
        dk_rem[g+1] <= rm[KW-1:0];
      end
    end

    assign fin_item = dk_item[NSTG];
    assign fin_t    = dk_w[NSTG];
  end

  // accumulate the new term
  always_ff @(posedge clk) begin
    if (rst) begin
      item_o.vld <= 1'b0;
    end else begin
      item_o.vld <= fin_item.vld;
    end
    item_o.q    <= fin_item.q;
    item_o.x    <= fin_item.x;
    item_o.term <= fin_t;
    item_o.sum  <= fin_item.sum + fin_t;
  end

endmodule

// ===== design/en2f_scale.sv =====
`timescale 1ns / 1ps
module en2f_scale #(
  parameter int EXP2_FRAC_BITS = 23
) (
  input  logic                 clk,
  input  logic                 rst,
  input  en2f_pkg::en2f_item_t item,
  input  logic [31:0]          ref_freq,
  output logic [31:0]          frequency,
  output logic                 saturated,
  output logic                 done
);
  import en2f_pkg::*;

  localparam int FW  = EXP2_FRAC_BITS + 2;
  localparam int PW  = 32 + FW;
  localparam int RND = WORK_FRAC - EXP2_FRAC_BITS;

  logic          f_vld;
  logic [7:0]    f_q;
  logic [FW-1:0] f_fac;
  logic [63:0]   rounded;

  assign rounded = (item.sum + (64'd1 << (RND - 1))) >> RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= item.vld;
    end
    f_q   <= item.q;
    f_fac <= rounded[FW-1:0];
  end

  logic          p_vld;
  logic [7:0]    p_q;
  logic [PW-1:0] p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= f_vld;
    end
    p_q    <= f_q;
    p_prod <= PW'(ref_freq) * PW'(f_fac);
  end

  // octave shift with clamp
  logic signed [8:0] sh;
  logic [8:0]        n;
  logic [PW+31:0]    shl;
  logic [PW-1:0]     shr;
  logic [31:0]       freq_next;
  logic              sat_next;

  assign sh = $signed({p_q[7], p_q}) - 9'(EXP2_FRAC_BITS);
  assign n  = 9'(-sh);

  always_comb begin
    shl       = {32'b0, p_prod} << sh[4:0];
    shr       = p_prod >> n[7:0];
    freq_next = '0;
    sat_next  = 1'b0;
    if (p_prod == '0) begin
      freq_next = '0;
    end else if (!sh[8]) begin
      if (sh >= 9'sd32 || |shl[PW+31:32]) begin
        sat_next = 1'b1;
      end else begin
        freq_next = shl[31:0];
      end
    end else begin
      if (|shr[PW-1:32]) begin
        sat_next = 1'b1;
      end else begin
        freq_next = shr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_vld;
    end
    frequency <= sat_next ? '1 : freq_next;
    saturated <= sat_next;
  end

endmodule

// ===== design/edo_note_to_frequency.sv =====
`timescale 1ns / 1ps
// note to pitch converter for an equal division of the octave
// frequency = reference_frequency * 2^((note - reference_note) / divisions),
// unsigned q16.16 in and out, divisions of zero count as one
// input: pulse start with a note while busy is low; busy is high only in reset
// output: done strobes for one cycle with frequency and saturated; the
//   receiver cannot hold it off, so every word must be taken on its strobe
// latency: 270 cycles from the accepting edge to the strobe
//   11 for the octave split and the r*ln2/d long division,
//   3 for the first series term and 11 for each of the other 23 terms
//   (a 64x64 product in 32-bit partials, then division by the term index),
//   3 for rounding, reference multiply and octave shift
// throughput: one word per cycle, every stage takes a new word each clock
// config: cfg_write with cfg_index and cfg_data, taken at once; write only
//   while nothing is in flight
// reset: sync, clears the registers to 440 Hz, note 69, 12 steps and
//   empties the pipeline
module edo_note_to_frequency #(
  parameter int EXP2_FRAC_BITS = 23
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [6:0]  note,
  output logic        busy,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] frequency,
  output logic        saturated
);
  import en2f_pkg::*;

  `include "assert_macros.svh"

  localparam int LATENCY = 11 + 3 + (TAYLOR_TERMS - 1) * 11 + 3;

  // config registers
  logic [31:0] ref_freq;
  logic [6:0]  ref_note;
  logic [7:0]  oct_div;
  logic [7:0]  divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq <= 32'd28835840;
      ref_note <= 7'd69;
      oct_div  <= 8'd12;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_FREQ: ref_freq <= cfg_data;
        REG_REF_NOTE: ref_note <= cfg_data[6:0];
        REG_OCT_DIV:  oct_div  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign divisor = (oct_div == '0) ? 8'd1 : oct_div;
  assign busy    = rst;

  // octave split and series argument
  en2f_item_t chain [0:TAYLOR_TERMS];

  en2f_xgen u_xgen (
    .clk      (clk),
    .rst      (rst),
    .take     (start && !busy),
    .note     (note),
    .ref_note (ref_note),
    .divisor  (divisor),
    .item     (chain[0])
  );

  // one pipeline section per taylor term
  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    en2f_term #(
      .K (k)
    ) u_term (
      .clk    (clk),
      .rst    (rst),
      .item_i (chain[k-1]),
      .item_o (chain[k])
    );
  end

  // round, scale by reference, shift by octaves
  en2f_scale #(
    .EXP2_FRAC_BITS (EXP2_FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .item      (chain[TAYLOR_TERMS]),
    .ref_freq  (ref_freq),
    .frequency (frequency),
    .saturated (saturated),
    .done      (done)
  );

  `EN2F_IMPLY(a_word_out, start && !busy, ##LATENCY done, "accepted word lost")
  `EN2F_IMPLY(a_no_phantom, done, $past(start && !busy, LATENCY), "result without word")
  `EN2F_IMPLY(a_sat_clamp, done && saturated, frequency == '1, "saturated not clamped")

endmodule
